// ----- rtl/bf4_pkg.sv -----
package bf4_pkg;

    // Default datapath parameters
    localparam int DEF_WORD_BITS     = 32;
    localparam int DEF_FRACTION_BITS = 16;

    // Remainder divider width in each fold lane; lane and estimate latencies
    localparam int DIV_BITS    = 35;
    localparam int FOLD_LAT    = DIV_BITS + 2;
    localparam int SQRT_STEPS  = 32;
    localparam int EST_LAT     = SQRT_STEPS + 7;
    localparam int AXES        = 4;

    // Register indexes
    localparam logic [2:0] CFG_SIZE_X = 3'd0;
    localparam logic [2:0] CFG_SIZE_Y = 3'd1;
    localparam logic [2:0] CFG_SIZE_Z = 3'd2;
    localparam logic [2:0] CFG_SIZE_W = 3'd3;
    localparam logic [2:0] CFG_MODE   = 3'd4;
    localparam logic [2:0] CFG_GAIN   = 3'd5;
    localparam logic [2:0] CFG_OFFSET = 3'd6;

    // Mode flag bits
    localparam int FLG_OFF  = 0;
    localparam int FLG_EN_X = 1;
    localparam int FLG_UPD  = 5;
    localparam int FLG_LEN  = 6;
    localparam int FLG_COPY = 7;

    typedef struct packed {
        logic [7:0]         flags;
        logic signed [31:0] gain;
        logic signed [31:0] offset;
    } t_cfg;

    // Saturate to a signed word of wb bits
    function automatic logic signed [31:0] f_sat(input logic signed [65:0] v, input int wb);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = (66'sd1 <<< (wb - 1)) - 66'sd1;
        lo = -hi - 66'sd1;
        if (v > hi) return hi[31:0];
        if (v < lo) return lo[31:0];
        return v[31:0];
    endfunction

    // Round product magnitude half away from zero, apply sign, saturate
    function automatic logic signed [31:0] f_rsat(input logic [63:0] p, input logic neg,
                                                  input int fb, input int wb);
        logic [64:0]        t;
        logic signed [65:0] v;
        t = {1'b0, p} + (65'd1 << (fb - 1));
        t = t >> fb;
        v = neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
        return f_sat(v, wb);
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

// ----- rtl/bf4_in_if.sv -----
interface bf4_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] point_w;
    logic signed [31:0] estimate_in;

    modport source(output valid, point_x, point_y, point_z, point_w, estimate_in,
                   input ready);
    modport sink(input valid, point_x, point_y, point_z, point_w, estimate_in,
                 output ready);
endinterface

// ----- rtl/bf4_out_if.sv -----
interface bf4_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] folded_x;
    logic signed [31:0] folded_y;
    logic signed [31:0] folded_z;
    logic signed [31:0] folded_w;
    logic signed [31:0] estimate_out;
    logic               orbit_copy;

    modport source(output valid, folded_x, folded_y, folded_z, folded_w, estimate_out,
                   orbit_copy, input ready);
    modport sink(input valid, folded_x, folded_y, folded_z, folded_w, estimate_out,
                 orbit_copy, output ready);
endinterface

// ----- rtl/bf4_fold_lane.sv -----
module bf4_fold_lane import bf4_pkg::*; #(
    parameter int WB = DEF_WORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_on,
    input  logic signed [31:0] i_v,
    input  logic signed [31:0] i_s,
    output logic signed [31:0] o_f
);
    localparam int NW = DIV_BITS;

    logic [NW-1:0]      r_num [0:NW];
    logic [NW-1:0]      r_den [0:NW];
    logic [NW-1:0]      r_rem [0:NW];
    logic signed [31:0] r_v   [0:NW];
    logic signed [31:0] r_s   [0:NW];
    logic               r_on  [0:NW];
    logic signed [31:0] r_f;

    logic [NW:0]        n_sh  [0:NW-1];
    logic [NW-1:0]      n_rem [0:NW-1];

    logic [33:0]        am_in;
    logic [31:0]        av_in;
    logic [NW-1:0]      am_out;
    logic signed [36:0] t_d, t_r, t_s, t_a, t_b, t_fold;

    // Period magnitude 4|s| and rounded-quotient numerator/denominator
    always_comb begin
        am_in = i_s[31] ? 34'(-({{2{i_s[31]}}, i_s} <<< 2)) : 34'({2'b00, i_s} << 2);
        av_in = f_mag(i_v);
    end

    // One remainder bit per stage
    always_comb begin
        for (int j = 0; j < NW; j++) begin
            n_sh[j] = {r_rem[j], r_num[j][NW-1-j]};
            if (n_sh[j] >= {1'b0, r_den[j]}) begin
                n_rem[j] = NW'(n_sh[j] - {1'b0, r_den[j]});
            end else begin
                n_rem[j] = n_sh[j][NW-1:0];
            end
        end
    end

    // Wrapped residue from remainder, then box fold
    always_comb begin
        am_out = r_den[NW] >> 1;
        t_d    = $signed({2'b00, r_rem[NW]}) - $signed({2'b00, am_out});
        t_r    = r_v[NW][31] ? -(t_d >>> 1) : (t_d >>> 1);
        t_s    = 37'(r_s[NW]);
        t_a    = t_r + t_s;
        t_b    = t_r - t_s;
        t_fold = (t_a[36] ? -t_a : t_a) - (t_b[36] ? -t_b : t_b) - t_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= (NW'(av_in) << 1) + NW'(am_in);
            r_den[0] <= NW'(am_in) << 1;
            r_rem[0] <= '0;
            r_v[0]   <= i_v;
            r_s[0]   <= i_s;
            r_on[0]  <= i_on;
            for (int j = 0; j < NW; j++) begin
                r_num[j+1] <= r_num[j];
                r_den[j+1] <= r_den[j];
                r_rem[j+1] <= n_rem[j];
                r_v[j+1]   <= r_v[j];
                r_s[j+1]   <= r_s[j];
                r_on[j+1]  <= r_on[j];
            end
            r_f <= r_on[NW] ? f_sat(66'(t_fold), WB) : f_sat(66'(r_v[NW]), WB);
        end
    end

    assign o_f = r_f;
endmodule

// ----- rtl/bf4_est.sv -----
module bf4_est import bf4_pkg::*; #(
    parameter int WB = DEF_WORD_BITS,
    parameter int FB = DEF_FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic signed [31:0] i_p [AXES],
    input  logic signed [31:0] i_de,
    output logic signed [31:0] o_p [AXES],
    output logic signed [31:0] o_de
);
    logic signed [31:0] r_pd [EST_LAT][AXES];
    logic [63:0]        r_sq [AXES];
    logic signed [31:0] r_de0;
    logic [63:0]        r_sn [0:SQRT_STEPS];
    logic [63:0]        r_sr [0:SQRT_STEPS];
    logic signed [31:0] r_sd [0:SQRT_STEPS];
    logic [63:0]        r_m1p, r_m3p;
    logic               r_m1n, r_m3n;
    logic signed [31:0] r_m1d, r_m2d, r_m2d0, r_m3d0, r_m4d, r_m4d0, r_out;

    logic [65:0]        n_sum;
    logic [63:0]        n_bit [SQRT_STEPS];
    logic [63:0]        n_t   [SQRT_STEPS];
    logic [63:0]        n_sn  [SQRT_STEPS];
    logic [63:0]        n_sr  [SQRT_STEPS];

    // Sum of squares, saturated at 2^64-1
    always_comb begin
        n_sum = 66'(r_sq[0]) + 66'(r_sq[1]) + 66'(r_sq[2]) + 66'(r_sq[3]);
    end

    // Digit-by-digit square root, one result bit per stage
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            n_bit[k] = 64'd1 << (62 - 2 * k);
            n_t[k]   = r_sr[k] + n_bit[k];
            if (r_sn[k] >= n_t[k]) begin
                n_sn[k] = r_sn[k] - n_t[k];
                n_sr[k] = (r_sr[k] >> 1) + n_bit[k];
            end else begin
                n_sn[k] = r_sn[k];
                n_sr[k] = r_sr[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // point delay line
            r_pd[0] <= i_p;
            for (int d = 1; d < EST_LAT; d++) begin
                r_pd[d] <= r_pd[d-1];
            end
            // squares
            for (int i = 0; i < AXES; i++) begin
                r_sq[i] <= 64'(f_mag(i_p[i])) * 64'(f_mag(i_p[i]));
            end
            r_de0 <= f_sat(66'(i_de), WB);
            // sum into root pipe
            r_sn[0] <= n_sum[65:64] != 2'b00 ? '1 : n_sum[63:0];
            r_sr[0] <= '0;
            r_sd[0] <= r_de0;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_sn[k+1] <= n_sn[k];
                r_sr[k+1] <= n_sr[k];
                r_sd[k+1] <= r_sd[k];
            end
            // estimate times length when length mode is on
            r_m1p  <= 64'(f_mag(r_sd[SQRT_STEPS])) * 64'(r_sr[SQRT_STEPS][31:0]);
            r_m1n  <= r_sd[SQRT_STEPS][31];
            r_m1d  <= r_sd[SQRT_STEPS];
            r_m2d  <= i_cfg.flags[FLG_LEN] ? f_rsat(r_m1p, r_m1n, FB, WB) : r_m1d;
            r_m2d0 <= r_m1d;
            // estimate times gain
            r_m3p  <= 64'(f_mag(r_m2d)) * 64'(f_mag(i_cfg.gain));
            r_m3n  <= r_m2d[31] ^ i_cfg.gain[31];
            r_m3d0 <= r_m2d0;
            r_m4d  <= f_rsat(r_m3p, r_m3n, FB, WB);
            r_m4d0 <= r_m3d0;
            // offset, or plain pass when update is off
            r_out  <= i_cfg.flags[FLG_UPD] ? f_sat(66'(r_m4d) + 66'(i_cfg.offset), WB)
                                           : r_m4d0;
        end
    end

    assign o_p  = r_pd[EST_LAT-1];
    assign o_de = r_out;
endmodule

// ----- rtl/box_fold_4d_tiled.sv -----
// Tiled 4D box fold: four lanes wrap and fold x, y, z, w in parallel, each
// through a 35-stage remainder divider; a merge stage then forms the
// distance estimate (squares, a 32-stage square root, two rounded products
// and the offset, as the mode flags select). One item is taken every
// cycle; the whole pipeline holds while a result waits at the output.
// Configuration must be written only with the pipeline empty.
module box_fold_4d_tiled import bf4_pkg::*; #(
    parameter int WORD_BITS     = DEF_WORD_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    bf4_in_if.sink      i_pt,
    bf4_out_if.source   o_res
);
    localparam int WB  = WORD_BITS < 16 ? 16 : (WORD_BITS > 32 ? 32 : WORD_BITS);
    localparam int FB  = FRACTION_BITS < 1 ? 1 : (FRACTION_BITS > 32 ? 32 : FRACTION_BITS);
    localparam int LAT = FOLD_LAT + EST_LAT;

    logic signed [31:0] r_size [AXES];
    logic [7:0]         r_flags;
    logic signed [31:0] r_gain, r_offset;
    logic [LAT-1:0]     r_vld;
    logic signed [31:0] r_de_d [FOLD_LAT];

    logic               en;
    logic signed [31:0] pt [AXES];
    logic signed [31:0] fold [AXES];
    logic signed [31:0] res [AXES];
    logic signed [31:0] de_out;
    t_cfg               cfg;

    assign en = !r_vld[LAT-1] || o_res.ready;
    assign i_pt.ready = en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) r_size[i] <= 32'sd65536;
            r_flags  <= 8'h02;
            r_gain   <= 32'sd65536;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_X: r_size[0] <= i_cfg_data;
                CFG_SIZE_Y: r_size[1] <= i_cfg_data;
                CFG_SIZE_Z: r_size[2] <= i_cfg_data;
                CFG_SIZE_W: r_size[3] <= i_cfg_data;
                CFG_MODE:   r_flags   <= i_cfg_data[7:0];
                CFG_GAIN:   r_gain    <= i_cfg_data;
                CFG_OFFSET: r_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid pipe, one bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    // Estimate waits alongside the fold lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_de_d[0] <= i_pt.estimate_in;
            for (int d = 1; d < FOLD_LAT; d++) r_de_d[d] <= r_de_d[d-1];
        end
    end

    assign pt[0] = i_pt.point_x;
    assign pt[1] = i_pt.point_y;
    assign pt[2] = i_pt.point_z;
    assign pt[3] = i_pt.point_w;

    // Fold lanes
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        bf4_fold_lane #(.WB(WB)) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_on  (!r_flags[FLG_OFF] && r_flags[FLG_EN_X+g] && r_size[g] != 32'sd0),
            .i_v   (pt[g]),
            .i_s   (r_size[g]),
            .o_f   (fold[g])
        );
    end

    assign cfg = '{flags: r_flags, gain: r_gain, offset: r_offset};

    // Merge: estimate update
    bf4_est #(.WB(WB), .FB(FB)) u_est (
        .i_clk (i_clk),
        .i_en  (en),
        .i_cfg (cfg),
        .i_p   (fold),
        .i_de  (r_de_d[FOLD_LAT-1]),
        .o_p   (res),
        .o_de  (de_out)
    );

    assign o_res.valid        = r_vld[LAT-1];
    assign o_res.folded_x     = res[0];
    assign o_res.folded_y     = res[1];
    assign o_res.folded_z     = res[2];
    assign o_res.folded_w     = res[3];
    assign o_res.estimate_out = de_out;
    assign o_res.orbit_copy   = r_flags[FLG_COPY];
endmodule

// ----- rtl/bf4_chk.sv -----
module bf4_chk import bf4_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_idx,
    input logic [31:0] i_cfg_data,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x,
    input logic [31:0] i_out_de,
    input logic        i_out_copy
);
    logic r_copy;

    // Shadow of the copy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == CFG_MODE) begin
            r_copy <= i_cfg_data[FLG_COPY];
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_x) && $stable(i_out_de))
        else $error("result changed while stalled");

    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_copy == r_copy)
        else $error("orbit copy flag mismatch");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input blocked with output free");
endmodule

bind box_fold_4d_tiled bf4_chk u_bf4_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.folded_x),
    .i_out_de    (o_res.estimate_out),
    .i_out_copy  (o_res.orbit_copy)
);

// ----- verif/box_fold_4d_tiled_tb.sv -----
module box_fold_4d_tiled_tb;
    import bf4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH   = FOLD_LAT + EST_LAT;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 300;

    typedef struct {
        logic signed [31:0] x, y, z, w, est;
    } t_point;

    typedef struct {
        logic signed [31:0] x, y, z, w, est;
        logic               copy;
    } t_fold_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CFG_SIZE_X;
    logic [31:0] i_cfg_data = '0;

    bf4_in_if  pt_if();
    bf4_out_if res_if();

    box_fold_4d_tiled dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the configuration registers
    longint    axis_size [4];
    logic [7:0] flags_cfg;
    longint    gain_cfg, offset_cfg;

    t_point    pending_pts[$];
    t_fold_res expected_res[$];
    int        mismatches = 0;
    int        results_seen = 0;
    bit        full_rate = 1'b0;
    bit        accepted_any;

    // ---------------- fixed-point predictor ----------------
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Wrap by period 4*s (half away from zero), then box fold
    function automatic logic signed [31:0] fold_lane(longint v, longint s);
        longint per, q, stp, r;
        per = abs64(s * 4);
        q   = (2 * abs64(v) + per) / (2 * per);
        stp = q * per;
        r   = v < 0 ? v + stp : v - stp;
        return clamp32(abs64(r + s) - abs64(r - s) - r);
    endfunction

    // Exact product, magnitude rounded half away from zero, saturated
    function automatic logic signed [31:0] mul_round(longint a, longint b);
        bit        neg;
        bit [63:0] ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma  = a < 0 ? 64'(-a) : 64'(a);
        mb  = b < 0 ? 64'(-b) : 64'(b);
        p   = (ma * mb + 64'd32768) >> 16;
        return clamp32(neg ? -longint'(p) : longint'(p));
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] n);
        bit [63:0] res, b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_fold_res predict_fold(t_point pt);
        t_fold_res  r;
        longint     c [4];
        longint     e;
        bit [63:0]  sum, a;
        bit [64:0]  acc;
        c[0] = pt.x; c[1] = pt.y; c[2] = pt.z; c[3] = pt.w;
        for (int i = 0; i < AXES; i++) begin
            if (!flags_cfg[FLG_OFF] && flags_cfg[FLG_EN_X + i] && axis_size[i] != 0)
                c[i] = longint'(fold_lane(c[i], axis_size[i]));
        end
        e = pt.est;
        if (flags_cfg[FLG_UPD]) begin
            if (flags_cfg[FLG_LEN]) begin
                sum = '0;
                for (int i = 0; i < AXES; i++) begin
                    a   = 64'(abs64(c[i]));
                    acc = {1'b0, sum} + 65'(a * a);
                    sum = acc[64] ? '1 : acc[63:0];
                end
                e = longint'(mul_round(e, longint'(int_sqrt(sum))));
            end
            e = longint'(mul_round(e, gain_cfg));
            e = longint'(clamp32(e + offset_cfg));
        end
        r.x = 32'(c[0]); r.y = 32'(c[1]); r.z = 32'(c[2]); r.w = 32'(c[3]);
        r.est  = 32'(e);
        r.copy = flags_cfg[FLG_COPY];
        return r;
    endfunction

    // ---------------- point driver ----------------
    int sender_gap = 0;

    always @(posedge i_clk) begin
        bit     taken;
        bit     nxt_valid;
        t_point p;
        taken     = pt_if.valid && pt_if.ready;
        nxt_valid = pt_if.valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (taken) begin
                p.x = pt_if.point_x; p.y = pt_if.point_y; p.z = pt_if.point_z;
                p.w = pt_if.point_w; p.est = pt_if.estimate_in;
                expected_res.push_back(predict_fold(p));
                sender_gap = full_rate ? 0 :
                             ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
                             ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            end
            if (!pt_if.valid || taken) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                    nxt_valid = 1'b0;
                end else if (pending_pts.size() > 0) begin
                    p = pending_pts.pop_front();
                    pt_if.point_x     <= p.x;
                    pt_if.point_y     <= p.y;
                    pt_if.point_z     <= p.z;
                    pt_if.point_w     <= p.w;
                    pt_if.estimate_in <= p.est;
                    nxt_valid = 1'b1;
                end else begin
                    nxt_valid = 1'b0;
                end
            end
        end
        pt_if.valid <= nxt_valid;
    end

    // ---------------- result receiver ----------------
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AT) begin
            // one long back-pressure stretch so the pipeline fills and stalls
            long_hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (full_rate) begin
            res_if.ready <= 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
            hold_left = $urandom_range(10, 60);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_fold_res ex;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (expected_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result item x=%h est=%h",
                             res_if.folded_x, res_if.estimate_out);
            end else begin
                ex = expected_res.pop_front();
                if (res_if.folded_x !== ex.x || res_if.folded_y !== ex.y ||
                    res_if.folded_z !== ex.z || res_if.folded_w !== ex.w ||
                    res_if.estimate_out !== ex.est || res_if.orbit_copy !== ex.copy) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: item %0d exp %h %h %h %h est %h cp %b, ",
                                  "got %h %h %h %h est %h cp %b"},
                                 results_seen, ex.x, ex.y, ex.z, ex.w, ex.est, ex.copy,
                                 res_if.folded_x, res_if.folded_y, res_if.folded_z,
                                 res_if.folded_w, res_if.estimate_out, res_if.orbit_copy);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        accepted_any = (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready);
        if (accepted_any || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SIZE_X: axis_size[0] = longint'(signed'(data));
            CFG_SIZE_Y: axis_size[1] = longint'(signed'(data));
            CFG_SIZE_Z: axis_size[2] = longint'(signed'(data));
            CFG_SIZE_W: axis_size[3] = longint'(signed'(data));
            CFG_MODE:   flags_cfg    = data[7:0];
            CFG_GAIN:   gain_cfg     = longint'(signed'(data));
            CFG_OFFSET: offset_cfg   = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [31:0] sw, logic [7:0] md, logic [31:0] gn,
                             logic [31:0] ofs);
        reg_write(CFG_SIZE_X, sx);
        reg_write(CFG_SIZE_Y, sy);
        reg_write(CFG_SIZE_Z, sz);
        reg_write(CFG_SIZE_W, sw);
        reg_write(CFG_MODE, {24'd0, md});
        reg_write(CFG_GAIN, gn);
        reg_write(CFG_OFFSET, ofs);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for the pipeline to empty before touching registers
    task automatic drain_pipe();
        while (pending_pts.size() != 0 || pt_if.valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic queue_pt(longint x, longint y, longint z, longint w, longint e);
        t_point p;
        p.x = clamp32(x); p.y = clamp32(y); p.z = clamp32(z); p.w = clamp32(w);
        p.est = clamp32(e);
        pending_pts.push_back(p);
    endtask

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h0;
            2: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            default: return 32'(longint'($urandom_range(1, 8 << 16)) *
                                ($urandom_range(0, 3) == 0 ? -1 : 1));
        endcase
    endfunction

    // Coordinates aimed at period boundaries, extremes and ordinary values
    function automatic longint rand_coord(longint s);
        longint k;
        k = longint'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 5))
            0: return longint'(signed'($urandom()));
            1: return s * 2 * (2 * k + 1);
            2: return s * 2 * (2 * k + 1) + (longint'($urandom_range(0, 4)) - 2);
            3: return ($urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648);
            default: return longint'($urandom_range(0, 16 << 16)) - (8 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            default: return 32'(longint'($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    initial begin
        axis_size = '{65536, 65536, 65536, 65536};
        flags_cfg = 8'h02;
        gain_cfg = 65536;
        offset_cfg = 0;
        pt_if.valid = 1'b0;
        pt_if.point_x = '0; pt_if.point_y = '0; pt_if.point_z = '0;
        pt_if.point_w = '0; pt_if.estimate_in = '0;
        res_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: x folds with size 1.0; half-period and extreme points
        queue_pt(0, 1, 2, 3, 65536);
        queue_pt(-64'sd2147483648, -64'sd2147483648, 0, 0, -64'sd2147483648);
        queue_pt(64'sd2147483647, 64'sd2147483647, 0, 0, 64'sd2147483647);
        queue_pt(2 << 16, 0, 0, 0, 0);
        queue_pt(-(2 << 16), 0, 0, 0, 0);
        queue_pt(6 << 16, 0, 0, 0, 0);
        queue_pt(98304, -98304, 0, 0, 12345);
        drain_pipe();

        // Most negative, most positive, zero and negative sizes; length mode on
        write_all(32'h80000000, 32'h7fffffff, 32'h0, 32'hfffe8000, 8'hfe,
                  32'h7fffffff, 32'h80000000);
        queue_pt(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                 -64'sd2147483648, 64'sd2147483647);
        queue_pt(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                 64'sd2147483647, -64'sd2147483648);
        queue_pt(0, 0, 0, 0, 65536);
        queue_pt(65536, -3 << 16, 7 << 16, 3 << 16, 65536);
        queue_pt(-65536, 1, -1, -98304, -65536);
        drain_pipe();

        // Fold off with every other flag set, extreme gain and offset
        write_all(32'h00010000, 32'h00020000, 32'h00008000, 32'h00030000, 8'hff,
                  32'h80000000, 32'h7fffffff);
        queue_pt(5 << 16, -5 << 16, 3, -3, 65536);
        queue_pt(0, 0, 0, 0, -64'sd2147483648);
        queue_pt(65536, 65536, 65536, 65536, 64'sd2147483647);
        drain_pipe();

        // Everything off; then update without length mode
        write_all(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 8'h00,
                  32'h00018000, 32'h00001000);
        queue_pt(3 << 16, 3 << 16, 3 << 16, 3 << 16, 65536);
        queue_pt(-64'sd2147483648, 64'sd2147483647, 0, 0, 7);
        drain_pipe();
        write_all(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 8'h3e,
                  32'h00018000, 32'hffff0000);
        queue_pt(3 << 16, -(2 << 16), 98304, 1, 65537);
        queue_pt(-64'sd2147483648, 64'sd2147483647, -1, 0, -98305);
        drain_pipe();

        // Random phases, bursty traffic with every third phase at full rate
        for (int ph = 0; ph < 11; ph++) begin
            write_all(rand_size(), rand_size(), rand_size(), rand_size(),
                      8'($urandom_range(0, 255) & ($urandom_range(0, 2) ? 8'hfe : 8'hff)),
                      rand_word(), rand_word());
            full_rate = (ph % 3 == 2);
            for (int n = 0; n < 104; n++)
                queue_pt(rand_coord(axis_size[0]), rand_coord(axis_size[1]),
                         rand_coord(axis_size[2]), rand_coord(axis_size[3]),
                         longint'(signed'(rand_word())));
            drain_pipe();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bf4_pkg.sv
rtl/bf4_in_if.sv
rtl/bf4_out_if.sv
rtl/bf4_fold_lane.sv
rtl/bf4_est.sv
rtl/box_fold_4d_tiled.sv
rtl/bf4_chk.sv
verif/box_fold_4d_tiled_tb.sv
